FILE: rtl/core/rv32ssc_pkg.sv
// ----------------------------------------------------------------------------
// rv32ssc_pkg: shared definitions for the rv32 subset core
// opcodes, function codes, field widths and the result item layout
// ----------------------------------------------------------------------------
`default_nettype none

package rv32ssc_pkg;

    // item widths
    localparam int unsigned XLEN       = 32;
    localparam int unsigned REG_IDX_W  = 5;
    localparam int unsigned REG_COUNT  = 32;
    localparam int unsigned MEM_WORDS  = 32;
    localparam int unsigned MEM_IDX_W  = $clog2(MEM_WORDS);
    localparam int unsigned S_TDATA_W  = 32;
    localparam int unsigned M_TDATA_W  = 80;

    // major opcodes
    localparam logic [6:0] OPC_ALU_REG = 7'b0110011;
    localparam logic [6:0] OPC_LOAD    = 7'b0000011;
    localparam logic [6:0] OPC_ALU_IMM = 7'b0010011;
    localparam logic [6:0] OPC_STORE   = 7'b0100011;
    localparam logic [6:0] OPC_BRANCH  = 7'b1100011;

    // funct7 codes
    localparam logic [6:0] F7_BASE = 7'b0000000;
    localparam logic [6:0] F7_SUB  = 7'b0100000;

    // funct3 codes
    localparam logic [2:0] F3_ADD  = 3'b000;
    localparam logic [2:0] F3_WORD = 3'b010;
    localparam logic [2:0] F3_OR   = 3'b110;
    localparam logic [2:0] F3_AND  = 3'b111;
    localparam logic [2:0] F3_BEQ  = 3'b000;
    localparam logic [2:0] F3_BNE  = 3'b001;

    // result item, first field in the highest bits
    typedef struct packed {
        logic                 illegal;
        logic                 branch_taken;
        logic [MEM_IDX_W-1:0] mem_index;
        logic                 mem_we;
        logic [XLEN-1:0]      reg_value;
        logic [REG_IDX_W-1:0] reg_dest;
        logic                 reg_we;
        logic [XLEN-1:0]      next_pc;
    } result_t;

    localparam int unsigned RESULT_W = $bits(result_t);

endpackage : rv32ssc_pkg

`default_nettype wire

FILE: rtl/core/rv32_subset_single_cycle_core_unit.sv
// ----------------------------------------------------------------------------
// rv32_subset_single_cycle_core_unit: rv32i subset core, one instruction per item
// executes ADD, SUB, AND, OR, ADDI, LW, SW, BEQ and BNE against local pc,
// register file and data memory, and reports next pc and the writes made
// ----------------------------------------------------------------------------
// pipeline: an accepted item passes the execute stage register, then the output
// stage register that drives m_tvalid; an output stall holds both stages
// throughput: one item per cycle unless the output stalls; operand reads are
// registered at accept with a bypass from the instruction retiring in that cycle
// reset: pc cleared, register file and data memory read as zero through
// per-entry valid bits, both pipeline stages emptied
`default_nettype none

module rv32_subset_single_cycle_core_unit (
    input  wire                                aclk,
    input  wire                                aresetn,
    // instr_word[31:0]
    input  wire  [rv32ssc_pkg::S_TDATA_W-1:0]  s_tdata,
    input  wire                                s_tvalid,
    output logic                               s_tready,
    // next_pc[31:0], reg_we[32], reg_dest[37:33], reg_value[69:38],
    // mem_we[70], mem_index[75:71], branch_taken[76], illegal[77], zeros[79:78]
    output logic [rv32ssc_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic                               m_tvalid,
    input  wire                                m_tready
);
    import rv32ssc_pkg::*;

    // architectural state
    logic [XLEN-1:0]      pc_reg;
    logic [XLEN-1:0]      rf_reg [REG_COUNT];
    logic [REG_COUNT-1:0] rf_valid_reg;
    logic [XLEN-1:0]      dm_reg [MEM_WORDS];
    logic [MEM_WORDS-1:0] dm_valid_reg;

    // execute stage
    logic            ex_valid_reg;
    logic [XLEN-1:0] ir_reg;
    logic [XLEN-1:0] rs1_data_reg;
    logic [XLEN-1:0] rs2_data_reg;

    // output stage
    logic    out_valid_reg;
    result_t out_reg;

    logic    advance;
    logic    retire;
    logic    s_take;
    result_t res_next;

    // decode and execute signals
    logic [6:0]           opc;
    logic [2:0]           f3;
    logic [6:0]           f7;
    logic [REG_IDX_W-1:0] rd;
    logic [XLEN-1:0]      imm_i;
    logic [XLEN-1:0]      imm_s;
    logic [XLEN-1:0]      imm_b;
    logic [XLEN-1:0]      addr_sum;
    logic [MEM_IDX_W-1:0] idx;
    logic [XLEN-1:0]      load_word;
    logic                 we;
    logic                 mwe;
    logic                 taken;
    logic                 bad;
    logic [XLEN-1:0]      val;
    logic                 wb_we;
    logic [REG_IDX_W-1:0] rs1_addr;
    logic [REG_IDX_W-1:0] rs2_addr;
    logic [XLEN-1:0]      rs1_rd;
    logic [XLEN-1:0]      rs2_rd;

    // handshake
    assign advance  = !out_valid_reg || m_tready;
    assign retire   = ex_valid_reg && advance;
    assign s_tready = !ex_valid_reg || advance;
    assign s_take   = s_tvalid && s_tready;

    // instruction fields
    assign opc   = ir_reg[6:0];
    assign rd    = ir_reg[11:7];
    assign f3    = ir_reg[14:12];
    assign f7    = ir_reg[31:25];
    assign imm_i = {{20{ir_reg[31]}}, ir_reg[31:20]};
    assign imm_s = {{20{ir_reg[31]}}, ir_reg[31:25], ir_reg[11:7]};
    assign imm_b = {{19{ir_reg[31]}}, ir_reg[31], ir_reg[7], ir_reg[30:25],
                    ir_reg[11:8], 1'b0};

    // address adder shared by load, store and ADDI
    assign addr_sum  = rs1_data_reg + ((opc == OPC_STORE) ? imm_s : imm_i);
    assign idx       = addr_sum[MEM_IDX_W-1:0];
    assign load_word = dm_valid_reg[idx] ? dm_reg[idx] : '0;

    // instruction decoder and alu
    always_comb begin
        we    = 1'b0;
        mwe   = 1'b0;
        taken = 1'b0;
        bad   = 1'b0;
        val   = '0;
        unique case (opc)
            OPC_ALU_REG: begin
                if (f3 == F3_ADD && f7 == F7_BASE) begin
                    val = rs1_data_reg + rs2_data_reg;
                    we  = 1'b1;
                end else if (f3 == F3_ADD && f7 == F7_SUB) begin
                    val = rs1_data_reg - rs2_data_reg;
                    we  = 1'b1;
                end else if (f3 == F3_OR && f7 == F7_BASE) begin
                    val = rs1_data_reg | rs2_data_reg;
                    we  = 1'b1;
                end else if (f3 == F3_AND && f7 == F7_BASE) begin
                    val = rs1_data_reg & rs2_data_reg;
                    we  = 1'b1;
                end else begin
                    bad = 1'b1;
                end
            end
            OPC_ALU_IMM: begin
                if (f3 == F3_ADD) begin
                    val = addr_sum;
                    we  = 1'b1;
                end else begin
                    bad = 1'b1;
                end
            end
            OPC_LOAD: begin
                if (f3 == F3_WORD) begin
                    val = load_word;
                    we  = 1'b1;
                end else begin
                    bad = 1'b1;
                end
            end
            OPC_STORE: begin
                if (f3 == F3_WORD) begin
                    mwe = 1'b1;
                end else begin
                    bad = 1'b1;
                end
            end
            OPC_BRANCH: begin
                if (f3 == F3_BEQ) begin
                    taken = (rs1_data_reg == rs2_data_reg);
                end else if (f3 == F3_BNE) begin
                    taken = (rs1_data_reg != rs2_data_reg);
                end else begin
                    bad = 1'b1;
                end
            end
            default: begin
                bad = 1'b1;
            end
        endcase
    end

    // writes to x0 are dropped
    assign wb_we = we && (rd != '0);

    // result item
    always_comb begin
        res_next              = '0;
        res_next.next_pc      = taken ? (pc_reg + imm_b) : (pc_reg + XLEN'(4));
        res_next.reg_we       = wb_we;
        res_next.reg_dest     = wb_we ? rd : '0;
        res_next.reg_value    = wb_we ? val : '0;
        res_next.mem_we       = mwe;
        res_next.mem_index    = (opc == OPC_LOAD || opc == OPC_STORE) && !bad ? idx : '0;
        res_next.branch_taken = taken;
        res_next.illegal      = bad;
    end

    // operand read with bypass from the retiring instruction
    assign rs1_addr = s_tdata[19:15];
    assign rs2_addr = s_tdata[24:20];

    always_comb begin
        if (rs1_addr == '0) begin
            rs1_rd = '0;
        end else if (retire && wb_we && rd == rs1_addr) begin
            rs1_rd = val;
        end else if (rf_valid_reg[rs1_addr]) begin
            rs1_rd = rf_reg[rs1_addr];
        end else begin
            rs1_rd = '0;
        end
        if (rs2_addr == '0) begin
            rs2_rd = '0;
        end else if (retire && wb_we && rd == rs2_addr) begin
            rs2_rd = val;
        end else if (rf_valid_reg[rs2_addr]) begin
            rs2_rd = rf_reg[rs2_addr];
        end else begin
            rs2_rd = '0;
        end
    end

    // execute stage register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ex_valid_reg <= 1'b0;
        end else if (s_tready) begin
            ex_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_take) begin
            ir_reg       <= s_tdata[XLEN-1:0];
            rs1_data_reg <= rs1_rd;
            rs2_data_reg <= rs2_rd;
        end
    end

    // program counter and valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg       <= '0;
            rf_valid_reg <= '0;
            dm_valid_reg <= '0;
        end else if (retire) begin
            pc_reg <= res_next.next_pc;
            if (wb_we) begin
                rf_valid_reg[rd] <= 1'b1;
            end
            if (mwe) begin
                dm_valid_reg[idx] <= 1'b1;
            end
        end
    end

    // register file and data memory arrays
    always_ff @(posedge aclk) begin
        if (retire && wb_we) begin
            rf_reg[rd] <= val;
        end
        if (retire && mwe) begin
            dm_reg[idx] <= rs2_data_reg;
        end
    end

    // output stage register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= ex_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (retire) begin
            out_reg <= res_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(M_TDATA_W - RESULT_W)'(0), out_reg};

    // x0 is never reported as written
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && out_reg.reg_we |-> out_reg.reg_dest != '0)
        else $error("x0 reported as written");

    // an illegal instruction makes no writes and no branch
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && out_reg.illegal |->
            !out_reg.reg_we && !out_reg.mem_we && !out_reg.branch_taken)
        else $error("illegal instruction had side effects");

    // a retired instruction always lands in the output stage
    assert property (@(posedge aclk) disable iff (!aresetn)
        retire |=> m_tvalid)
        else $error("retired instruction lost");

    // pc only moves when an instruction retires
    assert property (@(posedge aclk) disable iff (!aresetn)
        !retire |=> $stable(pc_reg))
        else $error("pc changed without retire");

endmodule : rv32_subset_single_cycle_core_unit

`default_nettype wire

FILE: tb/sv/rv32_subset_single_cycle_core_unit_tb.sv
// ----------------------------------------------------------------------------
// rv32_subset_single_cycle_core_unit_tb: self-checking bench for the rv32 subset core
// streams instruction words into the core and keeps its own copy of pc, register
// file and data memory to predict next pc, writes, branch and illegal flags of
// every result item; directed corner cases first, then random programs and noise
// ----------------------------------------------------------------------------
`default_nettype none

module rv32_subset_single_cycle_core_unit_tb;

    import rv32ssc_pkg::*;

    // encodings outside the subset, used to provoke the illegal flag
    localparam logic [6:0] OPC_JAL  = 7'b1101111;
    localparam logic [2:0] F3_XOR   = 3'b100;
    localparam logic [2:0] F3_BLT   = 3'b100;
    localparam logic [6:0] F7_MULDV = 7'b0000001;

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned DRAIN_WAIT  = 8;

    // operation kinds for the random program generator
    typedef enum int unsigned {
        K_ADD, K_SUB, K_AND, K_OR, K_ADDI, K_LW, K_SW, K_BEQ, K_BNE
    } op_kind_e;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic [S_TDATA_W-1:0]  s_tdata  = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;

    // architectural copy of the core state
    logic [XLEN-1:0] arch_pc;
    logic [XLEN-1:0] arch_regs [REG_COUNT];
    logic [XLEN-1:0] arch_mem  [MEM_WORDS];

    result_t     retire_q [$];
    int unsigned fail_cnt    = 0;
    int unsigned sent_cnt    = 0;
    int unsigned checked_cnt = 0;
    int unsigned taken_cnt   = 0;
    int unsigned store_cnt   = 0;
    int unsigned load_cnt    = 0;
    int unsigned illegal_cnt = 0;
    int unsigned cycle_cnt   = 0;
    bit          src_idle_en = 1'b1;
    bit          snk_stall_en = 1'b1;

    rv32_subset_single_cycle_core_unit DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    // clock, period 8
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // run limit
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("FAIL rv32_subset_single_cycle_core_unit");
            $finish;
        end
    end

    // instruction encoders
    function automatic logic [31:0] enc_r(input logic [6:0] f7, input logic [4:0] rs2,
                                          input logic [4:0] rs1, input logic [2:0] f3,
                                          input logic [4:0] rd);
        return {f7, rs2, rs1, f3, rd, OPC_ALU_REG};
    endfunction

    function automatic logic [31:0] enc_i(input logic [11:0] imm, input logic [4:0] rs1,
                                          input logic [2:0] f3, input logic [4:0] rd,
                                          input logic [6:0] opc);
        return {imm, rs1, f3, rd, opc};
    endfunction

    function automatic logic [31:0] enc_s(input logic [11:0] imm, input logic [4:0] rs2,
                                          input logic [4:0] rs1, input logic [2:0] f3);
        return {imm[11:5], rs2, rs1, f3, imm[4:0], OPC_STORE};
    endfunction

    function automatic logic [31:0] enc_b(input logic [12:0] off, input logic [4:0] rs2,
                                          input logic [4:0] rs1, input logic [2:0] f3);
        return {off[12], off[10:5], rs2, rs1, f3, off[4:1], off[11], OPC_BRANCH};
    endfunction

    // executes one instruction on the architectural copy and returns its result item
    function automatic result_t execute_instr(input logic [31:0] iw);
        result_t         r;
        logic [6:0]      opc;
        logic [4:0]      rd;
        logic [2:0]      f3;
        logic [6:0]      f7;
        logic [XLEN-1:0] a, b, imm_i, imm_s, imm_b, sum, val;
        logic            we, bad;
        opc   = iw[6:0];
        rd    = iw[11:7];
        f3    = iw[14:12];
        f7    = iw[31:25];
        a     = (iw[19:15] == '0) ? '0 : arch_regs[iw[19:15]];
        b     = (iw[24:20] == '0) ? '0 : arch_regs[iw[24:20]];
        imm_i = {{20{iw[31]}}, iw[31:20]};
        imm_s = {{20{iw[31]}}, iw[31:25], iw[11:7]};
        imm_b = {{19{iw[31]}}, iw[31], iw[7], iw[30:25], iw[11:8], 1'b0};
        r     = '0;
        we    = 1'b0;
        bad   = 1'b0;
        val   = '0;
        r.next_pc = arch_pc + 32'd4;
        case (opc)
            OPC_ALU_REG: begin
                we = 1'b1;
                if (f3 == F3_ADD && f7 == F7_BASE)      val = a + b;
                else if (f3 == F3_ADD && f7 == F7_SUB)  val = a - b;
                else if (f3 == F3_OR && f7 == F7_BASE)  val = a | b;
                else if (f3 == F3_AND && f7 == F7_BASE) val = a & b;
                else begin
                    we  = 1'b0;
                    bad = 1'b1;
                end
            end
            OPC_ALU_IMM: begin
                if (f3 == F3_ADD) begin
                    val = a + imm_i;
                    we  = 1'b1;
                end else begin
                    bad = 1'b1;
                end
            end
            OPC_LOAD: begin
                if (f3 == F3_WORD) begin
                    sum         = a + imm_i;
                    r.mem_index = sum[MEM_IDX_W-1:0];
                    val         = arch_mem[r.mem_index];
                    we          = 1'b1;
                end else begin
                    bad = 1'b1;
                end
            end
            OPC_STORE: begin
                if (f3 == F3_WORD) begin
                    sum                   = a + imm_s;
                    r.mem_index           = sum[MEM_IDX_W-1:0];
                    arch_mem[r.mem_index] = b;
                    r.mem_we              = 1'b1;
                end else begin
                    bad = 1'b1;
                end
            end
            OPC_BRANCH: begin
                if (f3 == F3_BEQ)      r.branch_taken = (a == b);
                else if (f3 == F3_BNE) r.branch_taken = (a != b);
                else                   bad = 1'b1;
                if (r.branch_taken) r.next_pc = arch_pc + imm_b;
            end
            default: bad = 1'b1;
        endcase
        // writes to x0 are dropped
        if (we && rd != '0) begin
            arch_regs[rd] = val;
            r.reg_we      = 1'b1;
            r.reg_dest    = rd;
            r.reg_value   = val;
        end
        r.illegal = bad;
        arch_pc   = r.next_pc;
        return r;
    endfunction

    // sends one instruction item, predicts its result at acceptance
    task automatic send_instr(input logic [31:0] iw);
        result_t r;
        while (src_idle_en && $urandom_range(99) < 17) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= iw;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        r = execute_instr(iw);
        retire_q = {retire_q, r};
        sent_cnt++;
        if (r.branch_taken) taken_cnt++;
        if (r.mem_we) store_cnt++;
        if (r.illegal) illegal_cnt++;
        if (iw[6:0] == OPC_LOAD && !r.illegal) load_cnt++;
    endtask

    // stops sending and waits for every outstanding result
    task automatic drain_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (retire_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    // result sink with random stalls
    always @(negedge aclk) begin
        m_tready <= !(snk_stall_en && $urandom_range(99) < 17);
    end

    // result checker
    always @(posedge aclk) begin
        result_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = result_t'(m_tdata[RESULT_W-1:0]);
            if (retire_q.size() == 0) begin
                $error("unexpected result item %h", m_tdata);
                fail_cnt++;
            end else begin
                want = retire_q.pop_front();
                checked_cnt++;
                if (got.next_pc !== want.next_pc) begin
                    $error("next_pc exp %h got %h", want.next_pc, got.next_pc);
                    fail_cnt++;
                end
                if (got.reg_we !== want.reg_we) begin
                    $error("reg_we exp %b got %b", want.reg_we, got.reg_we);
                    fail_cnt++;
                end
                if (got.reg_dest !== want.reg_dest) begin
                    $error("reg_dest exp %0d got %0d", want.reg_dest, got.reg_dest);
                    fail_cnt++;
                end
                if (got.reg_value !== want.reg_value) begin
                    $error("reg_value exp %h got %h", want.reg_value, got.reg_value);
                    fail_cnt++;
                end
                if (got.mem_we !== want.mem_we) begin
                    $error("mem_we exp %b got %b", want.mem_we, got.mem_we);
                    fail_cnt++;
                end
                if (got.mem_index !== want.mem_index) begin
                    $error("mem_index exp %0d got %0d", want.mem_index, got.mem_index);
                    fail_cnt++;
                end
                if (got.branch_taken !== want.branch_taken) begin
                    $error("branch_taken exp %b got %b", want.branch_taken,
                           got.branch_taken);
                    fail_cnt++;
                end
                if (got.illegal !== want.illegal) begin
                    $error("illegal exp %b got %b", want.illegal, got.illegal);
                    fail_cnt++;
                end
                if (m_tdata[M_TDATA_W-1:RESULT_W] !== '0) begin
                    $error("pad exp 0 got %b", m_tdata[M_TDATA_W-1:RESULT_W]);
                    fail_cnt++;
                end
            end
        end
    end

    // random operand pickers, biased to a few registers so results get reused
    function automatic logic [4:0] pick_reg();
        return ($urandom_range(3) == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(7));
    endfunction

    function automatic logic [11:0] pick_imm();
        case ($urandom_range(7))
            0:       return 12'h800;
            1:       return 12'h7FF;
            2:       return 12'hFFF;
            3:       return 12'h000;
            default: return 12'($urandom());
        endcase
    endfunction

    function automatic logic [12:0] pick_offset();
        case ($urandom_range(5))
            0:       return 13'h1000;
            1:       return 13'h0FFE;
            default: return {12'($urandom()), 1'b0};
        endcase
    endfunction

    // one well-formed instruction with random operands
    function automatic logic [31:0] rand_legal();
        op_kind_e   k;
        logic [4:0] rs1, rs2;
        k   = op_kind_e'($urandom_range(K_BNE));
        rs1 = pick_reg();
        rs2 = ($urandom_range(4) == 0) ? rs1 : pick_reg();
        case (k)
            K_ADD:   return enc_r(F7_BASE, rs2, rs1, F3_ADD, pick_reg());
            K_SUB:   return enc_r(F7_SUB, rs2, rs1, F3_ADD, pick_reg());
            K_AND:   return enc_r(F7_BASE, rs2, rs1, F3_AND, pick_reg());
            K_OR:    return enc_r(F7_BASE, rs2, rs1, F3_OR, pick_reg());
            K_ADDI:  return enc_i(pick_imm(), rs1, F3_ADD, pick_reg(), OPC_ALU_IMM);
            K_LW:    return enc_i(pick_imm(), rs1, F3_WORD, pick_reg(), OPC_LOAD);
            K_SW:    return enc_s(pick_imm(), rs2, rs1, F3_WORD);
            K_BEQ:   return enc_b(pick_offset(), rs2, rs1, F3_BEQ);
            default: return enc_b(pick_offset(), rs2, rs1, F3_BNE);
        endcase
    endfunction

    // supported opcode with random function fields, mostly illegal
    function automatic logic [31:0] rand_broken();
        logic [6:0]  opc;
        logic [31:0] w;
        case ($urandom_range(4))
            0:       opc = OPC_ALU_REG;
            1:       opc = OPC_ALU_IMM;
            2:       opc = OPC_LOAD;
            3:       opc = OPC_STORE;
            default: opc = OPC_BRANCH;
        endcase
        w = $urandom();
        return {w[31:7], opc};
    endfunction

    // corner cases: immediate extremes, every operation, x0, wraps, illegal codes
    task automatic test_directed();
        send_instr(enc_i(12'h800, 5'd0, F3_ADD, 5'd1, OPC_ALU_IMM));
        send_instr(enc_i(12'h7FF, 5'd0, F3_ADD, 5'd2, OPC_ALU_IMM));
        send_instr(enc_i(12'hFFF, 5'd1, F3_ADD, 5'd31, OPC_ALU_IMM));
        send_instr(enc_r(F7_BASE, 5'd2, 5'd1, F3_ADD, 5'd4));
        send_instr(enc_r(F7_SUB, 5'd1, 5'd2, F3_ADD, 5'd5));
        send_instr(enc_r(F7_BASE, 5'd2, 5'd1, F3_OR, 5'd6));
        send_instr(enc_r(F7_BASE, 5'd1, 5'd4, F3_AND, 5'd7));
        // write to x0 dropped, then x0 read back as zero
        send_instr(enc_r(F7_BASE, 5'd2, 5'd1, F3_ADD, 5'd0));
        send_instr(enc_r(F7_BASE, 5'd0, 5'd0, F3_ADD, 5'd8));
        // address sum going negative and wrapping at 32 bits
        send_instr(enc_s(12'h800, 5'd4, 5'd2, F3_WORD));
        send_instr(enc_i(12'h01F, 5'd0, F3_WORD, 5'd9, OPC_LOAD));
        send_instr(enc_s(12'h7FF, 5'd31, 5'd4, F3_WORD));
        send_instr(enc_s(12'h000, 5'd2, 5'd0, F3_WORD));
        send_instr(enc_i(12'h000, 5'd0, F3_WORD, 5'd10, OPC_LOAD));
        send_instr(enc_i(12'h000, 5'd0, F3_WORD, 5'd0, OPC_LOAD));
        // branches: extreme offsets, taken and not taken
        send_instr(enc_b(13'h1000, 5'd1, 5'd1, F3_BEQ));
        send_instr(enc_b(13'h0FFE, 5'd2, 5'd1, F3_BNE));
        send_instr(enc_b(13'h0008, 5'd2, 5'd1, F3_BEQ));
        send_instr(enc_b(13'h0008, 5'd3, 5'd3, F3_BNE));
        // encodings outside the subset
        send_instr(enc_i(12'h010, 5'd1, F3_ADD, 5'd11, OPC_JAL));
        send_instr(enc_i(12'h010, 5'd1, F3_XOR, 5'd11, OPC_ALU_IMM));
        send_instr(enc_r(F7_MULDV, 5'd2, 5'd1, F3_ADD, 5'd11));
        send_instr(enc_r(F7_SUB, 5'd2, 5'd1, F3_OR, 5'd11));
        send_instr(enc_b(13'h0010, 5'd1, 5'd1, F3_BLT));
        send_instr(enc_i(12'h000, 5'd0, F3_ADD, 5'd11, OPC_LOAD));
        send_instr(enc_s(12'h000, 5'd1, 5'd0, F3_ADD));
        send_instr(32'hFFFF_FFFF);
        send_instr(32'h0000_0000);
    endtask

    // random programs, with a stretch where neither side idles
    task automatic test_random_programs(input int unsigned count);
        for (int unsigned i = 0; i < count; i++) begin
            if (i == count / 3) begin
                src_idle_en  = 1'b0;
                snk_stall_en = 1'b0;
            end
            if (i == count / 3 + 300) begin
                src_idle_en  = 1'b1;
                snk_stall_en = 1'b1;
            end
            send_instr(rand_legal());
        end
    endtask

    // broken encodings and raw random words mixed into legal code
    task automatic test_noise(input int unsigned count);
        for (int unsigned i = 0; i < count; i++) begin
            case ($urandom_range(3))
                0:       send_instr(32'($urandom()));
                1:       send_instr(rand_broken());
                default: send_instr(rand_legal());
            endcase
        end
    endtask

    initial begin
        arch_pc = '0;
        for (int i = 0; i < REG_COUNT; i++) arch_regs[i] = '0;
        for (int i = 0; i < MEM_WORDS; i++) arch_mem[i] = '0;

        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_directed();
        drain_results();
        test_random_programs(1300);
        drain_results();
        test_noise(500);
        drain_results();

        $display("ran %0d instructions, %0d results checked", sent_cnt, checked_cnt);
        $display("taken branches %0d, loads %0d, stores %0d, illegal %0d",
                 taken_cnt, load_cnt, store_cnt, illegal_cnt);
        if (fail_cnt == 0 && retire_q.size() == 0) begin
            $display("PASS rv32_subset_single_cycle_core_unit");
        end else begin
            $display("FAIL rv32_subset_single_cycle_core_unit");
        end
        $finish;
    end

endmodule : rv32_subset_single_cycle_core_unit_tb

`default_nettype wire

FILE: files.f
rtl/core/rv32ssc_pkg.sv
rtl/core/rv32_subset_single_cycle_core_unit.sv
tb/sv/rv32_subset_single_cycle_core_unit_tb.sv
